[rtl/i2a_pkg.sv]
// ============================================================================
// i2a_pkg - shared definitions for the integer to ASCII radix converter
// Constants, character table and the divider status type used by the
// converter top level and its iterative divider.
// ============================================================================
package i2a_pkg;

    // Default width of the signed input value.
    localparam int VALUE_WIDTH_DEF = 16;

    // Quotient bits resolved by the divider in one clock cycle.
    localparam int DIV_STEP_BITS = 8;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } i2a_div_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

[rtl/int16_to_ascii_radix_unit.sv]
// ============================================================================
// int16_to_ascii_radix_unit - signed integer to ASCII text converter
// Converts one signed value per input word into its ASCII digits in a
// programmable radix of 2 to 16, most significant character first.
// ============================================================================
//
// Usage. A number enters on the value channel (value_valid / value_ready)
// and leaves as a run of character words on the char channel (char_valid /
// char_ready); the final character of a number has last set. In radix ten a
// negative number is preceded by '-'; in other radices a negative number is
// printed as its raw two's complement pattern. Zero prints as "0".
// The radix register sits at byte address 0 of the APB port; values below
// two act as two and values above sixteen act as sixteen. Reset sets it to 10.
//
// Timing. The block takes one number at a time. Each digit passes the check
// state and then the iterative divider, and each emitted character needs a
// registered digit store read followed by the output load.
// value_ready is high only while the sequencer idles. The output register
// decouples the two sides: when the receiver stalls, the current character
// holds and the sequencer waits; the last character of a number may still
// wait while the next number is accepted. Reset clears all control state;
// no output word is pending after reset.
module int16_to_ascii_radix_unit #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2a_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [i2a_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [i2a_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // number input channel
    input  logic                              value_valid,
    output logic                              value_ready,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    // character output channel
    output logic                              char_valid,
    input  logic                              char_ready,
    output logic [i2a_pkg::CHAR_W-1:0]        character,
    output logic                              last
);
    import i2a_pkg::*;

    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam logic [CNT_W-1:0] MAX_DIGITS = CNT_W'(VALUE_WIDTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ZERO  = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;
    localparam logic [2:0] ST_PUT   = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     eff_radix;
    logic [RADIX_W-1:0]     eff_radix_reg;
    logic [VALUE_WIDTH-1:0] quot_reg;
    logic                   neg_pending_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       idx_reg;

    logic                   char_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   out_free;

    logic [DIGIT_W-1:0]     digit_store [VALUE_WIDTH];
    logic [DIGIT_W-1:0]     rd_digit_reg;

    logic                   cfg_write;
    logic                   accept;
    logic                   finished;
    logic                   div_start;
    logic                   digit_wr;
    logic [VALUE_WIDTH-1:0] div_quot;
    i2a_div_status_t        div_status;

    // ------------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_RADIX))
        begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_RADIX) ?
                    APB_DATA_W'(radix_reg) : '0;

    // Out-of-range radix values are clamped into two to sixteen.
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            eff_radix = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            eff_radix = RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Iterative divider, used for every digit.
    // ------------------------------------------------------------------------
    i2a_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (quot_reg),
        .divisor  (eff_radix_reg),
        .quotient (div_quot),
        .status   (div_status)
    );

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    assign value_ready = (state_reg == ST_IDLE);
    assign accept      = value_valid && value_ready;
    assign out_free    = !char_valid_reg || char_ready;

    // Digit extraction stops once the quotient reaches zero or the digit store is full.
    assign finished  = (quot_reg == '0) || (count_reg == MAX_DIGITS);
    assign div_start = (state_reg == ST_CHECK) && !finished;
    assign digit_wr  = (state_reg == ST_DIV) && div_status.done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!finished)
                begin
                    state_next = ST_DIV;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_ZERO;
                end
                else if (neg_pending_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_ZERO:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            eff_radix_reg   <= RADIX_RESET;
            quot_reg        <= '0;
            neg_pending_reg <= 1'b0;
            count_reg       <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                eff_radix_reg <= eff_radix;
                count_reg     <= '0;
                // Only decimal prints a sign; the magnitude of the most
                // negative value still fits as an unsigned pattern.
                if (value[VALUE_WIDTH-1] && (eff_radix == RADIX_DEC))
                begin
                    neg_pending_reg <= 1'b1;
                    quot_reg        <= VALUE_WIDTH'(~value + 1'b1);
                end
                else
                begin
                    neg_pending_reg <= 1'b0;
                    quot_reg        <= value;
                end
            end
            if (digit_wr)
            begin
                quot_reg  <= div_quot;
                count_reg <= count_reg + 1'b1;
            end
            if ((state_reg == ST_CHECK) && finished)
            begin
                idx_reg <= IDX_W'(count_reg - 1'b1);
            end
            if ((state_reg == ST_PUT) && out_free && (idx_reg != '0))
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Digit store, least significant digit first, registered read.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (digit_wr)
        begin
            digit_store[count_reg[IDX_W-1:0]] <= div_status.remainder;
        end
        rd_digit_reg <= digit_store[idx_reg];
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (out_free &&
                 ((state_reg == ST_ZERO) || (state_reg == ST_SIGN) ||
                  (state_reg == ST_PUT)))
        begin
            char_valid_reg <= 1'b1;
        end
        else if (char_ready)
        begin
            char_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (state_reg == ST_ZERO)
            begin
                char_reg <= CHAR_ZERO;
                last_reg <= 1'b1;
            end
            else if (state_reg == ST_SIGN)
            begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
            end
            else if (state_reg == ST_PUT)
            begin
                char_reg <= digit_char(rd_digit_reg);
                last_reg <= (idx_reg == '0);
            end
        end
    end

    assign char_valid = char_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;

endmodule

[rtl/i2a_div.sv]
// ============================================================================
// i2a_div - iterative divider by a small radix
// Restoring division of an unsigned value by a divisor of 2 to 16, a fixed
// number of quotient bits per cycle, with a one-cycle done pulse at the end.
// ============================================================================
module i2a_div #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VALUE_WIDTH-1:0]        dividend,
    input  logic [i2a_pkg::RADIX_W-1:0]   divisor,
    output logic [VALUE_WIDTH-1:0]        quotient,
    output i2a_pkg::i2a_div_status_t      status
);
    import i2a_pkg::*;

    localparam int STEPS = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_W = STEPS * DIV_STEP_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic [PAD_W-1:0]   work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // One cycle of the restoring division: for each of DIV_STEP_BITS dividend
    // bits, shift the bit in, try to subtract, and record its quotient bit.
    always_comb
    begin
        logic [RADIX_W-1:0]       trial;
        logic [DIGIT_W-1:0]       r;
        logic [DIV_STEP_BITS-1:0] qb;
        r  = rem_reg;
        qb = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {r, work_reg[PAD_W-1-i]};
            if (trial >= div_reg)
            begin
                r = DIGIT_W'(trial - div_reg);
                qb[DIV_STEP_BITS-1-i] = 1'b1;
            end
            else
            begin
                r = trial[DIGIT_W-1:0];
            end
        end
        rem_next = r;
        if (PAD_W > DIV_STEP_BITS)
        begin
            work_next = PAD_W'({work_reg, qb});
        end
        else
        begin
            work_next = PAD_W'(qb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= PAD_W'(dividend);
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient         = work_reg[VALUE_WIDTH-1:0];
    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

endmodule
